// ===== rtl/mreq_pkg.sv =====
// Shared constants, codes and helpers for the multi-reader event queue.
package mreq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int READER_SLOTS = 8;

  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int SPAN_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ACTION_W = 3;
  localparam int TYPE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int PAY_W    = 32;
  localparam int CID_W    = 3;
  localparam int TID_W    = 32;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = TYPE_W + LEN_W + PAY_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_EVENT    = 3'd0,
    ACT_ADD_CONSUMER = 3'd1,
    ACT_DEL_CONSUMER = 3'd2,
    ACT_PEEK         = 3'd3,
    ACT_TAKE         = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NO_SLOT    = 3'd2,
    ST_UNKNOWN    = 3'd3,
    ST_NOTHING    = 3'd4,
    ST_INACTIVE   = 3'd5
  } status_e;

  typedef struct packed {
    logic [TYPE_W-1:0] etype;
    logic [LEN_W-1:0]  elen;
    logic [PAY_W-1:0]  epay;
  } entry_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ===== rtl/mreq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mreq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/multi_reader_event_queue.sv =====
// Broadcast event queue: ring of events with per-reader pending masks.
// Each request is latched, executed and its result registered in a done state; peek and take
//   first walk the span for the reader's oldest pending entry and read it, then take skips
//   freed head entries; del_consumer finds the slot, clears its bit over the span, then skips.
// Throughput: one request at a time, accepted the cycle after its predecessor's result registers.
// Reset clears pointers, span, reader slots and all pending masks at once; no clearing pass.
module multi_reader_event_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mreq_pkg::ACTION_W-1:0]    action_i,
  input  logic [mreq_pkg::TYPE_W-1:0]      event_type_i,
  input  logic [mreq_pkg::LEN_W-1:0]       message_length_i,
  input  logic [mreq_pkg::PAY_W-1:0]       payload_i,
  input  logic [mreq_pkg::CID_W-1:0]       consumer_id_i,
  input  logic [mreq_pkg::TID_W-1:0]       thread_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mreq_pkg::STATUS_W-1:0]    status_o,
  output logic [mreq_pkg::CID_W-1:0]       slot_given_o,
  output logic                             found_o,
  output logic [mreq_pkg::TYPE_W-1:0]      out_type_o,
  output logic [mreq_pkg::LEN_W-1:0]       out_length_o,
  output logic [mreq_pkg::PAY_W-1:0]       out_payload_o,
  output logic [mreq_pkg::SPAN_W-1:0]      entries_used_o
);
  import mreq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DSEARCH, S_DCLEAR, S_WALK, S_READ, S_SKIP, S_DONE
  } state_e;

  state_e                   state_q;
  logic [ACTION_W-1:0]      act_q;
  logic [TYPE_W-1:0]        type_q;
  logic [LEN_W-1:0]         len_q;
  logic [PAY_W-1:0]         pay_q;
  logic [CID_W-1:0]         cid_q;
  logic [TID_W-1:0]         tid_q;

  logic [PTR_W-1:0]         head_q, tail_q, p_q;
  logic [SPAN_W-1:0]        span_q, k_q;
  logic [CID_W-1:0]         s_q;
  logic [READER_SLOTS-1:0]  active_q;
  logic [TID_W-1:0]         slot_thread_q [READER_SLOTS];
  logic [READER_SLOTS-1:0]  pending_q [QUEUE_DEPTH];

  logic [STATUS_W-1:0]      st_q;
  logic [CID_W-1:0]         given_q;
  logic                     found_q;

  logic                     out_valid_q;
  logic [STATUS_W-1:0]      ostatus_q;
  logic [CID_W-1:0]         ogiven_q;
  logic                     ofound_q;
  logic [TYPE_W-1:0]        otype_q;
  logic [LEN_W-1:0]         olen_q;
  logic [PAY_W-1:0]         opay_q;
  logic [SPAN_W-1:0]        oused_q;

  logic                     free_any;
  logic [CID_W-1:0]         free_idx;
  logic [PTR_W-1:0]         rd_idx;
  logic [READER_SLOTS-1:0]  pend_rd;
  logic                     walk_end, walk_hit, thread_hit, s_last;

  logic                     ram_we, ram_re;
  entry_t                   ram_wdata, ram_rdata;

  // Lowest free reader slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = READER_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_any = 1'b1;
        free_idx = CID_W'(i);
      end
    end
  end

  // One pending-mask read port: the head while skipping, the walk pointer otherwise.
  assign rd_idx     = (state_q == S_SKIP) ? head_q : p_q;
  assign pend_rd    = pending_q[rd_idx];
  assign walk_end   = (k_q == span_q);
  assign walk_hit   = pend_rd[cid_q];
  assign thread_hit = active_q[s_q] && (slot_thread_q[s_q] == tid_q);
  assign s_last     = (s_q == CID_W'(READER_SLOTS - 1));

  assign ram_we    = (state_q == S_EXEC) && (act_q == ACT_ADD_EVENT) && (active_q != '0)
                     && (span_q != SPAN_W'(QUEUE_DEPTH));
  assign ram_wdata = '{etype: type_q, elen: len_q, epay: pay_q};
  assign ram_re    = (state_q == S_WALK) && !walk_end && walk_hit;

  mreq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (p_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= '0;
      type_q      <= '0;
      len_q       <= '0;
      pay_q       <= '0;
      cid_q       <= '0;
      tid_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      p_q         <= '0;
      span_q      <= '0;
      k_q         <= '0;
      s_q         <= '0;
      active_q    <= '0;
      for (int i = 0; i < READER_SLOTS; i++) slot_thread_q[i] <= '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) pending_q[i] <= '0;
      st_q        <= ST_OK;
      given_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ostatus_q   <= ST_OK;
      ogiven_q    <= '0;
      ofound_q    <= 1'b0;
      otype_q     <= '0;
      olen_q      <= '0;
      opay_q      <= '0;
      oused_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q   <= action_i;
            type_q  <= event_type_i;
            len_q   <= message_length_i;
            pay_q   <= payload_i;
            cid_q   <= consumer_id_i;
            tid_q   <= thread_id_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          given_q <= (act_q == ACT_ADD_CONSUMER && free_any) ? free_idx : '0;
          found_q <= 1'b0;
          unique case (act_q)
            ACT_ADD_EVENT: begin
              state_q <= S_DONE;
              if (active_q != '0 && span_q == SPAN_W'(QUEUE_DEPTH)) begin
                st_q <= ST_FULL;
              end else begin
                st_q <= ST_OK;
                // Drop the event when no reader is active.
                if (active_q != '0) begin
                  pending_q[tail_q] <= active_q;
                  tail_q            <= ring_next(tail_q);
                  span_q            <= span_q + SPAN_W'(1);
                end
              end
            end
            ACT_ADD_CONSUMER: begin
              state_q <= S_DONE;
              if (free_any) begin
                st_q                    <= ST_OK;
                slot_thread_q[free_idx] <= tid_q;
                active_q[free_idx]      <= 1'b1;
              end else begin
                st_q <= ST_NO_SLOT;
              end
            end
            ACT_DEL_CONSUMER: begin
              st_q    <= ST_UNKNOWN;
              s_q     <= '0;
              state_q <= S_DSEARCH;
            end
            ACT_PEEK, ACT_TAKE: begin
              if (32'(cid_q) >= READER_SLOTS || !active_q[cid_q]) begin
                st_q    <= ST_INACTIVE;
                state_q <= S_DONE;
              end else begin
                st_q    <= ST_NOTHING;
                p_q     <= head_q;
                k_q     <= '0;
                state_q <= S_WALK;
              end
            end
            default: begin
              st_q    <= ST_OK;
              state_q <= S_DONE;
            end
          endcase
        end
        S_DSEARCH: begin
          if (thread_hit) begin
            active_q[s_q] <= 1'b0;
            st_q          <= ST_OK;
            p_q           <= head_q;
            k_q           <= '0;
            state_q       <= S_DCLEAR;
          end else if (s_last) begin
            state_q <= S_DONE;
          end else begin
            s_q <= s_q + CID_W'(1);
          end
        end
        S_DCLEAR: begin
          // Drop the released slot's bit from every entry in the span.
          if (walk_end) begin
            state_q <= S_SKIP;
          end else begin
            pending_q[p_q][s_q] <= 1'b0;
            p_q                 <= ring_next(p_q);
            k_q                 <= k_q + SPAN_W'(1);
          end
        end
        S_WALK: begin
          if (walk_end) begin
            state_q <= S_DONE;
          end else if (walk_hit) begin
            st_q    <= ST_OK;
            found_q <= 1'b1;
            if (act_q == ACT_TAKE) begin
              pending_q[p_q][cid_q] <= 1'b0;
            end
            state_q <= S_READ;
          end else begin
            p_q <= ring_next(p_q);
            k_q <= k_q + SPAN_W'(1);
          end
        end
        S_READ: begin
          state_q <= (act_q == ACT_TAKE) ? S_SKIP : S_DONE;
        end
        S_SKIP: begin
          // Advance the head past entries no reader still needs.
          if (span_q != '0 && pend_rd == '0) begin
            head_q <= ring_next(head_q);
            span_q <= span_q - SPAN_W'(1);
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            ostatus_q   <= st_q;
            ogiven_q    <= given_q;
            ofound_q    <= found_q;
            otype_q     <= found_q ? ram_rdata.etype : '0;
            olen_q      <= found_q ? ram_rdata.elen : '0;
            opay_q      <= found_q ? ram_rdata.epay : '0;
            oused_q     <= span_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = ostatus_q;
  assign slot_given_o   = ogiven_q;
  assign found_o        = ofound_q;
  assign out_type_o     = otype_q;
  assign out_length_o   = olen_q;
  assign out_payload_o  = opay_q;
  assign entries_used_o = oused_q;

  a_head_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> (span_q == '0 || pending_q[head_q] != '0))
    else $error("head entry is free while span is nonzero");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (span_q == '0) |-> (head_q == tail_q))
    else $error("empty ring with head and tail apart");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_DCLEAR) |-> (k_q <= span_q))
    else $error("walk counter ran past the span");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ofound_q) |-> (ostatus_q == ST_OK))
    else $error("event returned with a failing status");

  a_span_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(oused_q) <= QUEUE_DEPTH))
    else $error("reported span exceeds queue depth");

endmodule

// ===== tb/sv/multi_reader_event_queue_tb.sv =====
// Self-checking testbench for the multi-reader event queue.
module multi_reader_event_queue_tb;
  import mreq_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
  localparam logic [TID_W-1:0]    TID_LOW      = 32'h0000_0000;
  localparam logic [TID_W-1:0]    TID_HIGH     = 32'hFFFF_FFFF;
  localparam logic [TID_W-1:0]    TID_STRAY    = 32'h0BAD_F00D;
  localparam int TID_POOL_N   = 6;
  localparam int PHASES       = 4;
  localparam int PHASE_ITEMS  = 375;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 60;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [TYPE_W-1:0]   etype;
    logic [LEN_W-1:0]    elen;
    logic [PAY_W-1:0]    epay;
    logic [CID_W-1:0]    cid;
    logic [TID_W-1:0]    tid;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CID_W-1:0]    slot;
    logic                found;
    logic [TYPE_W-1:0]   otype;
    logic [LEN_W-1:0]    olen;
    logic [PAY_W-1:0]    opay;
    logic [SPAN_W-1:0]   used;
  } reply_t;

  typedef struct {
    req_t   rq;
    bit     typed;
    reply_t want;
  } row_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i         = '0;
  logic [TYPE_W-1:0]   event_type_i     = '0;
  logic [LEN_W-1:0]    message_length_i = '0;
  logic [PAY_W-1:0]    payload_i        = '0;
  logic [CID_W-1:0]    consumer_id_i    = '0;
  logic [TID_W-1:0]    thread_id_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [CID_W-1:0]    slot_given_o;
  logic                found_o;
  logic [TYPE_W-1:0]   out_type_o;
  logic [LEN_W-1:0]    out_length_o;
  logic [PAY_W-1:0]    out_payload_o;
  logic [SPAN_W-1:0]   entries_used_o;

  // tag riding along with the request on the port, for rows with a typed-in answer
  logic   typed_pend = 1'b0;
  reply_t typed_want = '0;

  reply_t reply_q [$];
  row_t   dir_rows [$];
  logic [TID_W-1:0] tid_pool [TID_POOL_N];

  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_asks    = 0;
  int sent_cnt     = 0;
  int dir_cnt      = 0;
  int checked_cnt  = 0;
  int mismatch_cnt = 0;
  int found_cnt    = 0;
  int full_cnt     = 0;
  int noslot_cnt   = 0;
  int unknown_cnt  = 0;

  // queue state as the testbench sees it
  logic [TYPE_W-1:0]       ev_type [QUEUE_DEPTH];
  logic [LEN_W-1:0]        ev_len  [QUEUE_DEPTH];
  logic [PAY_W-1:0]        ev_pay  [QUEUE_DEPTH];
  logic [READER_SLOTS-1:0] ev_pend [QUEUE_DEPTH];
  logic [PTR_W-1:0]        rd_head;
  logic [PTR_W-1:0]        wr_tail;
  int                      span_cnt;
  logic [TID_W-1:0]        slot_tid [READER_SLOTS];
  logic [READER_SLOTS-1:0] live_slots;

  multi_reader_event_queue DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .event_type_i     (event_type_i),
    .message_length_i (message_length_i),
    .payload_i        (payload_i),
    .consumer_id_i    (consumer_id_i),
    .thread_id_i      (thread_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_given_o     (slot_given_o),
    .found_o          (found_o),
    .out_type_o       (out_type_o),
    .out_length_o     (out_length_o),
    .out_payload_o    (out_payload_o),
    .entries_used_o   (entries_used_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [PTR_W-1:0] ptr_after(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % QUEUE_DEPTH);
  endfunction

  // advance the head over entries no reader still needs
  function automatic void pop_done_entries();
    while (span_cnt > 0 && ev_pend[rd_head] == '0) begin
      rd_head = ptr_after(rd_head);
      span_cnt--;
    end
  endfunction

  function automatic void clear_queue_state();
    rd_head    = '0;
    wr_tail    = '0;
    span_cnt   = 0;
    live_slots = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) ev_pend[i] = '0;
  endfunction

  function automatic reply_t next_reply(input req_t rq);
    reply_t rp;
    logic [PTR_W-1:0] p;
    bit done;
    rp   = '0;
    done = 1'b0;
    case (rq.act)
      ACT_ADD_EVENT: begin
        if (live_slots != '0) begin
          if (span_cnt >= QUEUE_DEPTH) begin
            rp.status = ST_FULL;
          end else begin
            ev_type[wr_tail] = rq.etype;
            ev_len[wr_tail]  = rq.elen;
            ev_pay[wr_tail]  = rq.epay;
            ev_pend[wr_tail] = live_slots;
            wr_tail = ptr_after(wr_tail);
            span_cnt++;
          end
        end
      end
      ACT_ADD_CONSUMER: begin
        rp.status = ST_NO_SLOT;
        for (int s = 0; s < READER_SLOTS; s++) begin
          if (!done && !live_slots[s]) begin
            slot_tid[s]   = rq.tid;
            live_slots[s] = 1'b1;
            rp.slot       = CID_W'(s);
            rp.status     = ST_OK;
            done          = 1'b1;
          end
        end
      end
      ACT_DEL_CONSUMER: begin
        rp.status = ST_UNKNOWN;
        for (int s = 0; s < READER_SLOTS; s++) begin
          if (!done && live_slots[s] && slot_tid[s] == rq.tid) begin
            live_slots[s] = 1'b0;
            p = rd_head;
            for (int k = 0; k < span_cnt; k++) begin
              ev_pend[p][s] = 1'b0;
              p = ptr_after(p);
            end
            pop_done_entries();
            rp.status = ST_OK;
            done      = 1'b1;
          end
        end
      end
      ACT_PEEK, ACT_TAKE: begin
        if (!live_slots[rq.cid]) begin
          rp.status = ST_INACTIVE;
        end else begin
          rp.status = ST_NOTHING;
          p = rd_head;
          for (int k = 0; k < span_cnt; k++) begin
            if (!done && ev_pend[p][rq.cid]) begin
              rp.status = ST_OK;
              rp.found  = 1'b1;
              rp.otype  = ev_type[p];
              rp.olen   = ev_len[p];
              rp.opay   = ev_pay[p];
              if (rq.act == ACT_TAKE) begin
                ev_pend[p][rq.cid] = 1'b0;
                pop_done_entries();
              end
              done = 1'b1;
            end
            p = ptr_after(p);
          end
        end
      end
      default: ;
    endcase
    rp.used = SPAN_W'(span_cnt);
    return rp;
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  function automatic req_t mk_req(input logic [ACTION_W-1:0] act, input logic [TYPE_W-1:0] etype,
                                  input logic [LEN_W-1:0] elen, input logic [PAY_W-1:0] epay,
                                  input logic [CID_W-1:0] cid, input logic [TID_W-1:0] tid);
    req_t rq;
    rq.act   = act;
    rq.etype = etype;
    rq.elen  = elen;
    rq.epay  = epay;
    rq.cid   = cid;
    rq.tid   = tid;
    return rq;
  endfunction

  function automatic reply_t mk_reply(input logic [STATUS_W-1:0] status,
                                      input logic [CID_W-1:0] slot, input logic found,
                                      input logic [TYPE_W-1:0] otype, input logic [LEN_W-1:0] olen,
                                      input logic [PAY_W-1:0] opay, input logic [SPAN_W-1:0] used);
    reply_t rp;
    rp.status = status;
    rp.slot   = slot;
    rp.found  = found;
    rp.otype  = otype;
    rp.olen   = olen;
    rp.opay   = opay;
    rp.used   = used;
    return rp;
  endfunction

  function automatic void add_row(input req_t rq, input bit typed, input reply_t want);
    row_t r;
    r.rq    = rq;
    r.typed = typed;
    r.want  = want;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic req_t random_req();
    req_t rq;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 35)      rq.act = ACT_ADD_EVENT;
    else if (pick < 47) rq.act = ACT_ADD_CONSUMER;
    else if (pick < 59) rq.act = ACT_DEL_CONSUMER;
    else if (pick < 74) rq.act = ACT_PEEK;
    else if (pick < 96) rq.act = ACT_TAKE;
    else                rq.act = ACTION_W'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
    rq.etype = TYPE_W'($urandom);
    rq.elen  = LEN_W'($urandom);
    rq.epay  = $urandom;
    rq.cid   = CID_W'($urandom);
    // mostly known threads so deletes hit; now and then a stray one
    if ($urandom_range(9) == 0) rq.tid = $urandom;
    else                        rq.tid = tid_pool[$urandom_range(TID_POOL_N - 1)];
    return rq;
  endfunction

  task automatic send_req(input req_t rq, input bit typed, input reply_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= rq.act;
    event_type_i     <= rq.etype;
    message_length_i <= rq.elen;
    payload_i        <= rq.epay;
    consumer_id_i    <= rq.cid;
    thread_id_i      <= rq.tid;
    typed_pend       <= typed;
    typed_want       <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  // hold off new requests until every reply is back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  always @(posedge clk_i) begin : scoreboard
    req_t   acc;
    reply_t want;
    reply_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        acc  = mk_req(action_i, event_type_i, message_length_i, payload_i, consumer_id_i,
                      thread_id_i);
        want = next_reply(acc);
        if (typed_pend) want = typed_want;
        if (want.found) found_cnt++;
        if (want.status == ST_FULL) full_cnt++;
        if (want.status == ST_NO_SLOT) noslot_cnt++;
        if (want.status == ST_UNKNOWN) unknown_cnt++;
        reply_q.insert(reply_q.size(), want);
      end
      if (out_valid_o && out_ready_i) begin
        got = mk_reply(status_o, slot_given_o, found_o, out_type_o, out_length_o, out_payload_o,
                       entries_used_o);
        checked_cnt++;
        if (reply_q.size() == 0) begin
          $display("%0t: reply with no request outstanding, actual 0x%0h", $time, got);
          mismatch_cnt++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("slot_given", want.slot, got.slot);
          check_field("found", want.found, got.found);
          check_field("out_type", want.otype, got.otype);
          check_field("out_length", want.olen, got.olen);
          check_field("out_payload", want.opay, got.opay);
          check_field("entries_used", want.used, got.used);
        end
      end
    end
  end

  initial begin : sink
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_served) begin
        holds_served++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : source
    req_t rq;
    int   burst_left;
    bit   burst_take;
    logic [CID_W-1:0] burst_cid;
    int   gap_tab   [PHASES];
    int   stall_tab [PHASES];

    gap_tab   = '{0, 49, 0, 17};
    stall_tab = '{0, 0, 49, 17};
    burst_left = 0;
    burst_take = 1'b0;
    burst_cid  = '0;
    clear_queue_state();
    tid_pool[0] = TID_LOW;
    tid_pool[1] = TID_HIGH;
    for (int i = 2; i < TID_POOL_N; i++) tid_pool[i] = $urandom;

    add_row(mk_req(ACT_PEEK, 0, 0, 0, 0, 0), 1, mk_reply(ST_INACTIVE, 0, 0, 0, 0, 0, 0));
    // no reader yet: event is dropped
    add_row(mk_req(ACT_ADD_EVENT, 8'h5A, 16'h1234, 32'hCAFE_0001, 0, 0), 1,
            mk_reply(ST_OK, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ACT_DEL_CONSUMER, 0, 0, 0, 0, TID_STRAY), 1,
            mk_reply(ST_UNKNOWN, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ACT_UNDEF_HI, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 3'd7, TID_HIGH), 1,
            mk_reply(ST_OK, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ACT_ADD_CONSUMER, 0, 0, 0, 0, TID_LOW), 1, mk_reply(ST_OK, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ACT_ADD_CONSUMER, 0, 0, 0, 0, TID_HIGH), 1, mk_reply(ST_OK, 1, 0, 0, 0, 0, 0));
    add_row(mk_req(ACT_TAKE, 0, 0, 0, 1, 0), 1, mk_reply(ST_NOTHING, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(ACT_ADD_EVENT, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0), 1,
            mk_reply(ST_OK, 0, 0, 0, 0, 0, 1));
    add_row(mk_req(ACT_ADD_EVENT, 0, 0, 0, 3'd7, TID_HIGH), 1, mk_reply(ST_OK, 0, 0, 0, 0, 0, 2));
    add_row(mk_req(ACT_PEEK, 0, 0, 0, 1, 0), 1,
            mk_reply(ST_OK, 0, 1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 2));
    add_row(mk_req(ACT_TAKE, 0, 0, 0, 0, 0), 1,
            mk_reply(ST_OK, 0, 1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 2));
    // last reader takes it: entry frees and the head moves on
    add_row(mk_req(ACT_TAKE, 0, 0, 0, 1, 0), 1,
            mk_reply(ST_OK, 0, 1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1));
    // same thread bound twice
    add_row(mk_req(ACT_ADD_CONSUMER, 0, 0, 0, 0, TID_HIGH), 1, mk_reply(ST_OK, 2, 0, 0, 0, 0, 1));
    for (int s = 3; s < READER_SLOTS; s++)
      add_row(mk_req(ACT_ADD_CONSUMER, 0, 0, 0, 0, TID_W'(32'h100 + s)), 1,
              mk_reply(ST_OK, CID_W'(s), 0, 0, 0, 0, 1));
    add_row(mk_req(ACT_ADD_CONSUMER, 0, 0, 0, 0, TID_STRAY), 1,
            mk_reply(ST_NO_SLOT, 0, 0, 0, 0, 0, 1));
    add_row(mk_req(ACT_DEL_CONSUMER, 0, 0, 0, 0, TID_HIGH), 0, '0);
    add_row(mk_req(ACT_PEEK, 0, 0, 0, 1, 0), 0, '0);
    add_row(mk_req(ACT_TAKE, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(ACT_ADD_EVENT, 8'h80, 16'h8000, 32'h8000_0000, 0, 0), 0, '0);
    add_row(mk_req(ACT_PEEK, 0, 0, 0, 3'd7, 0), 0, '0);
    add_row(mk_req(ACT_TAKE, 0, 0, 0, 2, 0), 0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    gap_pct   = 17;
    stall_pct = 17;
    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    dir_cnt = dir_rows.size();
    drain_replies();

    for (int ph = 0; ph < PHASES; ph++) begin
      gap_pct   = gap_tab[ph];
      stall_pct = stall_tab[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the output side long enough to back up the input
        if (ph == 0 && n == PHASE_ITEMS / 4) hold_asks <= hold_asks + 1;
        if (burst_left == 0 && $urandom_range(99) < 4) begin
          burst_left = $urandom_range(12, 20);
          burst_take = 1'($urandom_range(1));
          burst_cid  = CID_W'($urandom);
        end
        rq = random_req();
        if (burst_left > 0) begin
          burst_left--;
          rq.act = burst_take ? ACT_TAKE : ACT_ADD_EVENT;
          rq.cid = burst_cid;
        end
        send_req(rq, 1'b0, '0);
      end
      drain_replies();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests (%0d directed) over four idling mixes plus a long output hold-off.",
             sent_cnt, dir_cnt);
    $display("Checked %0d replies: %0d returned events, %0d full, %0d no slot, %0d unknown thread.",
             checked_cnt, found_cnt, full_cnt, noslot_cnt, unknown_cnt);
    if (mismatch_cnt == 0 && reply_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== multi_reader_event_queue.f =====
rtl/mreq_pkg.sv
rtl/mreq_ram.sv
rtl/multi_reader_event_queue.sv
tb/sv/multi_reader_event_queue_tb.sv
